@@ rtl/core/sat_pkg.sv @@
package sat_pkg;

  typedef enum logic [1:0] {
    CMD_INSERT = 2'd0,
    CMD_READ   = 2'd1,
    CMD_REMOVE = 2'd2,
    CMD_NONE   = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    ST_DONE  = 2'd0,
    ST_FULL  = 2'd1,
    ST_RANGE = 2'd2
  } status_e;

  // Source of the next entry index.
  typedef enum logic [2:0] {
    IDX_HOLD,
    IDX_TOP,
    IDX_POS,
    IDX_POS_INC,
    IDX_INC,
    IDX_DEC,
    IDX_ZERO
  } idx_sel_e;

  // Write address and data selection.
  typedef enum logic [1:0] {
    WR_KEY,
    WR_UP,
    WR_DOWN
  } wr_sel_e;

  localparam int unsigned CfgWidth = 5;
  localparam logic [CfgWidth-1:0] CapacityReset = 5'd16;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [31:0] key;
    logic [3:0]  position;
  } sat_req_t;

  typedef struct packed {
    logic [31:0] read_key;
    logic [4:0]  entry_count;
    logic [1:0]  status;
  } sat_rsp_t;

  typedef struct packed {
    logic     capture;
    idx_sel_e idx_sel;
    logic     rd_en;
    logic     wr_en;
    wr_sel_e  wr_sel;
    logic     cnt_inc;
    logic     cnt_dec;
    logic     set_status;
    status_e  status_val;
    logic     rkey_load;
    logic     rsp_load;
  } sat_ctl_t;

  typedef struct packed {
    logic [1:0] cmd;
    logic       full;
    logic       out_of_range;
    logic       count_zero;
    logic       idx_zero;
    logic       idx_at_last;
    logic       pos_at_last;
    logic       key_less;
    logic       out_free;
  } sat_stat_t;

endpackage

@@ rtl/core/sat_ram.sv @@
module sat_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ rtl/core/sat_ctrl.sv @@
module sat_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  sat_pkg::sat_stat_t stat_i,
  output sat_pkg::sat_ctl_t  ctl_o
);
  import sat_pkg::*;

  typedef enum logic [6:0] {
    S_IDLE   = 7'b0000001,
    S_DECODE = 7'b0000010,
    S_SCAN   = 7'b0000100,
    S_PUT    = 7'b0001000,
    S_RWAIT  = 7'b0010000,
    S_RSHIFT = 7'b0100000,
    S_RESP   = 7'b1000000
  } state_e;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d          = state_q;
    ctl_o            = '0;
    ctl_o.idx_sel    = IDX_HOLD;
    ctl_o.wr_sel     = WR_KEY;
    ctl_o.status_val = ST_DONE;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          ctl_o.capture = 1'b1;
          state_d       = S_DECODE;
        end
      end
      S_DECODE: begin
        case (stat_i.cmd)
          CMD_INSERT: begin
            if (stat_i.full) begin
              ctl_o.set_status = 1'b1;
              ctl_o.status_val = ST_FULL;
              state_d          = S_RESP;
            end else if (stat_i.count_zero) begin
              ctl_o.idx_sel = IDX_ZERO;
              state_d       = S_PUT;
            end else begin
              // Walk down from the top entry, moving keys no smaller than the new key up.
              ctl_o.idx_sel = IDX_TOP;
              ctl_o.rd_en   = 1'b1;
              state_d       = S_SCAN;
            end
          end
          CMD_READ: begin
            if (stat_i.out_of_range) begin
              ctl_o.set_status = 1'b1;
              ctl_o.status_val = ST_RANGE;
              state_d          = S_RESP;
            end else begin
              ctl_o.idx_sel = IDX_POS;
              ctl_o.rd_en   = 1'b1;
              state_d       = S_RWAIT;
            end
          end
          CMD_REMOVE: begin
            if (stat_i.out_of_range) begin
              ctl_o.set_status = 1'b1;
              ctl_o.status_val = ST_RANGE;
              state_d          = S_RESP;
            end else if (stat_i.pos_at_last) begin
              ctl_o.cnt_dec = 1'b1;
              state_d       = S_RESP;
            end else begin
              ctl_o.idx_sel = IDX_POS_INC;
              ctl_o.rd_en   = 1'b1;
              state_d       = S_RSHIFT;
            end
          end
          default: begin
            state_d = S_RESP;
          end
        endcase
      end
      S_SCAN: begin
        if (stat_i.key_less) begin
          // The new key belongs just above the entry just read.
          ctl_o.idx_sel = IDX_INC;
          state_d       = S_PUT;
        end else begin
          ctl_o.wr_en  = 1'b1;
          ctl_o.wr_sel = WR_UP;
          if (stat_i.idx_zero) begin
            state_d = S_PUT;
          end else begin
            ctl_o.idx_sel = IDX_DEC;
            ctl_o.rd_en   = 1'b1;
          end
        end
      end
      S_PUT: begin
        ctl_o.wr_en   = 1'b1;
        ctl_o.wr_sel  = WR_KEY;
        ctl_o.cnt_inc = 1'b1;
        state_d       = S_RESP;
      end
      S_RWAIT: begin
        ctl_o.rkey_load = 1'b1;
        state_d         = S_RESP;
      end
      S_RSHIFT: begin
        ctl_o.wr_en  = 1'b1;
        ctl_o.wr_sel = WR_DOWN;
        if (stat_i.idx_at_last) begin
          ctl_o.cnt_dec = 1'b1;
          state_d       = S_RESP;
        end else begin
          ctl_o.idx_sel = IDX_INC;
          ctl_o.rd_en   = 1'b1;
        end
      end
      S_RESP: begin
        if (stat_i.out_free) begin
          ctl_o.rsp_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  assign in_stall_o = (state_q != S_IDLE);

  // States that consume memory read data must follow a read issue.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SCAN || state_q == S_RWAIT || state_q == S_RSHIFT) |-> $past(ctl_o.rd_en))
    else $error("read data consumed without a preceding read");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl_o.rsp_load |-> stat_i.out_free)
    else $error("response loaded over an unsent response");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl_o.rsp_load |=> state_q == S_IDLE)
    else $error("controller did not return to idle after a response");

endmodule

@@ rtl/core/sat_datapath.sv @@
module sat_datapath #(
  parameter int unsigned DEPTH     = 16,
  parameter int unsigned KEY_WIDTH = 32
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  sat_pkg::sat_req_t                req_i,
  input  sat_pkg::sat_ctl_t                ctl_i,
  output sat_pkg::sat_stat_t               stat_o,
  input  logic                             cfg_valid_i,
  input  logic [sat_pkg::CfgWidth-1:0]     cfg_data_i,
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output sat_pkg::sat_rsp_t                out_rsp_o
);
  import sat_pkg::*;

  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam int unsigned PW = (CW > 4) ? CW : 4;
  localparam int unsigned LW = (CW > CfgWidth) ? CW : CfgWidth;

  sat_req_t              op_q;
  logic [CW-1:0]         cnt_q;
  logic [CfgWidth-1:0]   cap_q;
  logic [AW-1:0]         idx_q, idx_d;
  status_e               status_q;
  logic [31:0]           rkey_q;
  logic                  out_valid_q;
  sat_rsp_t              out_q;

  logic [KEY_WIDTH-1:0]  op_key;
  logic [KEY_WIDTH-1:0]  rdata;
  logic [KEY_WIDTH-1:0]  wdata;
  logic [AW-1:0]         waddr;
  logic [CW-1:0]         cnt_m1;
  logic                  full;
  logic                  out_free;

  assign op_key   = KEY_WIDTH'(op_q.key);
  assign cnt_m1   = cnt_q - CW'(1);
  assign full     = (cnt_q >= CW'(DEPTH)) || (LW'(cnt_q) >= LW'(cap_q));
  assign out_free = !out_valid_q || !out_stall_i;

  always_comb begin
    case (ctl_i.idx_sel)
      IDX_TOP:     idx_d = AW'(cnt_m1);
      IDX_POS:     idx_d = AW'(op_q.position);
      IDX_POS_INC: idx_d = AW'(op_q.position) + AW'(1);
      IDX_INC:     idx_d = idx_q + AW'(1);
      IDX_DEC:     idx_d = idx_q - AW'(1);
      IDX_ZERO:    idx_d = '0;
      default:     idx_d = idx_q;
    endcase
  end

  always_comb begin
    case (ctl_i.wr_sel)
      WR_UP: begin
        waddr = idx_q + AW'(1);
        wdata = rdata;
      end
      WR_DOWN: begin
        waddr = idx_q - AW'(1);
        wdata = rdata;
      end
      default: begin
        waddr = idx_q;
        wdata = op_key;
      end
    endcase
  end

  sat_ram #(
    .Width (KEY_WIDTH),
    .Depth (DEPTH)
  ) u_keys (
    .clk_i   (clk_i),
    .we_i    (ctl_i.wr_en),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .re_i    (ctl_i.rd_en),
    .raddr_i (idx_d),
    .rdata_o (rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= '0;
      cap_q       <= CapacityReset;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      idx_q <= idx_d;
      if (cfg_valid_i) begin
        cap_q <= cfg_data_i;
      end
      if (ctl_i.cnt_inc) begin
        cnt_q <= cnt_q + CW'(1);
      end else if (ctl_i.cnt_dec) begin
        cnt_q <= cnt_m1;
      end
      if (ctl_i.rsp_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.capture) begin
      op_q     <= req_i;
      status_q <= ST_DONE;
      rkey_q   <= '0;
    end else begin
      if (ctl_i.set_status) begin
        status_q <= ctl_i.status_val;
      end
      if (ctl_i.rkey_load) begin
        rkey_q <= 32'(rdata);
      end
    end
    if (ctl_i.rsp_load) begin
      out_q.read_key    <= rkey_q;
      out_q.entry_count <= 5'(cnt_q);
      out_q.status      <= status_q;
    end
  end

  assign stat_o.cmd          = op_q.cmd;
  assign stat_o.full         = full;
  assign stat_o.out_of_range = PW'(op_q.position) >= PW'(cnt_q);
  assign stat_o.count_zero   = (cnt_q == '0);
  assign stat_o.idx_zero     = (idx_q == '0);
  assign stat_o.idx_at_last  = (CW'(idx_q) == cnt_m1);
  assign stat_o.pos_at_last  = (PW'(op_q.position) == PW'(cnt_m1));
  assign stat_o.key_less     = (rdata < op_key);
  assign stat_o.out_free     = out_free;

  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CW'(DEPTH))
    else $error("entry count beyond the store depth");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl_i.cnt_inc |-> !full && CW'(waddr) <= cnt_q)
    else $error("insert committed into a full table or above the count");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl_i.cnt_dec |-> cnt_q != '0)
    else $error("remove with an empty table");

endmodule

@@ rtl/core/sorted_array_table_core.sv @@
// Sorted key table: one request at a time, one response per request.
// Insert and remove shift the keys one entry a cycle through the single write
// port of the key memory. The next request is taken once the response has been
// loaded into the output register; an output stall can hold that back.
// Reset clears the count and sets the capacity limit to 16; keys are not cleared.
module sorted_array_table_core #(
  parameter int unsigned DEPTH     = 16,
  parameter int unsigned KEY_WIDTH = 32
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  sat_pkg::sat_req_t            in_req_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output sat_pkg::sat_rsp_t            out_rsp_o,
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [sat_pkg::CfgWidth-1:0] cfg_data_i
);
  import sat_pkg::*;

  sat_ctl_t  ctl;
  sat_stat_t stat;

  // The limit register takes a write in any cycle.
  assign cfg_ready_o = 1'b1;

  sat_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .stat_i     (stat),
    .ctl_o      (ctl)
  );

  sat_datapath #(
    .DEPTH     (DEPTH),
    .KEY_WIDTH (KEY_WIDTH)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_i       (in_req_i),
    .ctl_i       (ctl),
    .stat_o      (stat),
    .cfg_valid_i (cfg_valid_i && cfg_ready_o),
    .cfg_data_i  (cfg_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_rsp_o   (out_rsp_o)
  );

endmodule

@@ tb/sat_table_checker.sv @@
module sat_table_checker #(
  parameter int unsigned DEPTH = 16
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  input  logic                         in_stall_i,
  input  sat_pkg::sat_req_t            in_req_i,
  input  logic                         out_valid_i,
  input  logic                         out_stall_i,
  input  sat_pkg::sat_rsp_t            out_rsp_i,
  input  logic                         cfg_valid_i,
  input  logic                         cfg_ready_i,
  input  logic [sat_pkg::CfgWidth-1:0] cfg_data_i,
  output int unsigned                  fails_o,
  output int unsigned                  pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  import sat_pkg::*;

  logic [31:0]         shadow_keys [DEPTH];
  int unsigned         shadow_count;
  logic [CfgWidth-1:0] shadow_cap;
  sat_rsp_t            owed_answers_q [$];
  sat_rsp_t            oldest_answer;
  int unsigned         fail_tally;

  // Applies one request to the shadow table and returns the answer it owes.
  function automatic sat_rsp_t table_op(sat_req_t r);
    sat_rsp_t    a;
    int unsigned lim;
    int unsigned at;
    int unsigned j;
    status_e     st;
    logic [31:0] rk;
    lim = (shadow_cap < DEPTH) ? shadow_cap : DEPTH;
    st  = ST_DONE;
    rk  = '0;
    case (cmd_e'(r.cmd))
      CMD_INSERT: begin
        if (shadow_count >= lim) begin
          st = ST_FULL;
        end else begin
          // The new key goes ahead of any equal keys.
          at = 0;
          while (at < shadow_count && shadow_keys[at] < r.key) at++;
          for (j = shadow_count; j > at; j--) shadow_keys[j] = shadow_keys[j-1];
          shadow_keys[at] = r.key;
          shadow_count++;
        end
      end
      CMD_READ: begin
        if (r.position < shadow_count) begin
          rk = shadow_keys[r.position];
        end else begin
          st = ST_RANGE;
        end
      end
      CMD_REMOVE: begin
        if (r.position >= shadow_count) begin
          st = ST_RANGE;
        end else begin
          for (j = r.position; j + 1 < shadow_count; j++) shadow_keys[j] = shadow_keys[j+1];
          shadow_count--;
        end
      end
      default: begin
      end
    endcase
    a.read_key    = rk;
    a.entry_count = shadow_count[4:0];
    a.status      = st;
    return a;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      shadow_count = 0;
      shadow_cap   = CapacityReset;
      owed_answers_q.delete();
      fail_tally   = 0;
    end else begin
      if (out_valid_i && !out_stall_i) begin
        if (owed_answers_q.size() == 0) begin
          $error("response with no request outstanding: read_key %h entry_count %0d status %0d",
                 out_rsp_i.read_key, out_rsp_i.entry_count, out_rsp_i.status);
          fail_tally++;
        end else begin
          oldest_answer = owed_answers_q.pop_front();
          if (out_rsp_i.read_key !== oldest_answer.read_key) begin
            $error("read_key expected %h actual %h", oldest_answer.read_key,
                   out_rsp_i.read_key);
            fail_tally++;
          end
          if (out_rsp_i.entry_count !== oldest_answer.entry_count) begin
            $error("entry_count expected %0d actual %0d", oldest_answer.entry_count,
                   out_rsp_i.entry_count);
            fail_tally++;
          end
          if (out_rsp_i.status !== oldest_answer.status) begin
            $error("status expected %0d actual %0d", oldest_answer.status,
                   out_rsp_i.status);
            fail_tally++;
          end
        end
      end
      if (cfg_valid_i && cfg_ready_i) shadow_cap = cfg_data_i;
      if (in_valid_i && !in_stall_i) owed_answers_q.push_back(table_op(in_req_i));
    end
    fails_o   <= fail_tally;
    pending_o <= owed_answers_q.size();
  end

endmodule

@@ tb/tb_sorted_array_table_core.sv @@
module tb_sorted_array_table_core;
  timeunit 1ns;
  timeprecision 1ps;

  import sat_pkg::*;

  localparam int unsigned CycleLimit   = 400000;
  localparam int unsigned SettleCycles = 24;
  localparam int unsigned PhaseItems   = 76;
  localparam int unsigned PhaseCount   = 9;

  logic                clk_i;
  logic                rst_ni;
  logic                in_valid;
  logic                in_stall;
  sat_req_t            in_req;
  logic                out_valid;
  logic                out_stall;
  sat_rsp_t            out_rsp;
  logic                cfg_valid;
  logic                cfg_ready;
  logic [CfgWidth-1:0] cfg_data;
  int unsigned         fails;
  int unsigned         pending;
  int unsigned         cycle_count;
  int unsigned         burst_left;

  sorted_array_table_core dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_req_i    (in_req),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_rsp_o   (out_rsp),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_data_i  (cfg_data)
  );

  sat_table_checker u_checker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_stall_i  (in_stall),
    .in_req_i    (in_req),
    .out_valid_i (out_valid),
    .out_stall_i (out_stall),
    .out_rsp_i   (out_rsp),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_i (cfg_ready),
    .cfg_data_i  (cfg_data),
    .fails_o     (fails),
    .pending_o   (pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    cycle_count = 0;
    while (cycle_count < CycleLimit) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("tb_sorted_array_table_core: done, errors");
    $finish;
  end

  function automatic sat_req_t make_req(cmd_e c, logic [31:0] k, logic [3:0] p);
    sat_req_t r;
    r.cmd      = c;
    r.key      = k;
    r.position = p;
    return r;
  endfunction

  // Small key pools give plenty of equal keys; positions lean towards low indexes.
  function automatic sat_req_t random_request(int unsigned insert_pct);
    sat_req_t    r;
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 4) begin
      r.cmd = CMD_NONE;
    end else if (roll < 4 + insert_pct) begin
      r.cmd = CMD_INSERT;
    end else if ($urandom_range(0, 1) == 0) begin
      r.cmd = CMD_READ;
    end else begin
      r.cmd = CMD_REMOVE;
    end
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4: r.key = $urandom();
      5, 6, 7:       r.key = $urandom_range(0, 7);
      8:             r.key = ($urandom_range(0, 1) == 0) ? 32'h0 : 32'hFFFF_FFFF;
      default:       r.key = 32'hFFFF_FFF8 | $urandom_range(0, 7);
    endcase
    if ($urandom_range(0, 2) == 0) begin
      r.position = 4'($urandom_range(0, 3));
    end else begin
      r.position = 4'($urandom_range(0, 15));
    end
    return r;
  endfunction

  task automatic offer_request(input sat_req_t r);
    in_valid <= 1'b1;
    in_req   <= r;
    @(posedge clk_i);
    while (in_stall) @(posedge clk_i);
    if (burst_left > 0) burst_left--;
    if (burst_left == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk_i);
      burst_left = ($urandom_range(0, 5) == 0) ? 48 : $urandom_range(1, 10);
    end
  endtask

  task automatic drain_table();
    in_valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_capacity(input logic [CfgWidth-1:0] v);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    @(posedge clk_i);
    while (!cfg_ready) @(posedge clk_i);
    cfg_valid <= 1'b0;
  endtask

  // Receiver: segments of differing stall density, and one long hold-off
  // while the sender keeps offering, so that the block backs up.
  initial begin
    int unsigned mode;
    int unsigned seg_len;
    int unsigned segments;
    bit          held;
    out_stall <= 1'b0;
    segments = 0;
    held     = 1'b0;
    wait (rst_ni);
    forever begin
      mode    = $urandom_range(0, 3);
      seg_len = $urandom_range(10, 60);
      repeat (seg_len) begin
        @(posedge clk_i);
        case (mode)
          0:       out_stall <= 1'b0;
          1:       out_stall <= ($urandom_range(0, 3) == 0);
          2:       out_stall <= ($urandom_range(0, 1) == 0);
          default: out_stall <= ($urandom_range(0, 3) != 0);
        endcase
      end
      segments++;
      if (!held && segments == 40) begin
        held = 1'b1;
        @(posedge clk_i);
        out_stall <= 1'b1;
        repeat (400) @(posedge clk_i);
      end
    end
  end

  initial begin
    logic [CfgWidth-1:0] phase_caps [PhaseCount];
    int unsigned         insert_pct;
    rst_ni     <= 1'b0;
    in_valid   <= 1'b0;
    in_req     <= '0;
    cfg_valid  <= 1'b0;
    cfg_data   <= '0;
    burst_left = 4;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Empty table at the reset limit: refused reads and removes, unused command.
    offer_request(make_req(CMD_READ, 32'h0, 4'd0));
    offer_request(make_req(CMD_REMOVE, 32'hFFFF_FFFF, 4'd0));
    offer_request(make_req(CMD_NONE, 32'hA5A5_5A5A, 4'd15));
    // Extremes and an equal key, which must land ahead of its twin.
    offer_request(make_req(CMD_INSERT, 32'h0000_0005, 4'd0));
    offer_request(make_req(CMD_INSERT, 32'hFFFF_FFFF, 4'd15));
    offer_request(make_req(CMD_INSERT, 32'h0000_0000, 4'd0));
    offer_request(make_req(CMD_INSERT, 32'h0000_0005, 4'd0));
    offer_request(make_req(CMD_INSERT, 32'h8000_0000, 4'd0));
    for (int i = 0; i < 5; i++) offer_request(make_req(CMD_READ, 32'h0, 4'(i)));
    offer_request(make_req(CMD_READ, 32'h0, 4'd15));
    offer_request(make_req(CMD_READ, 32'h0, 4'd5));
    offer_request(make_req(CMD_REMOVE, 32'h0, 4'd4));
    offer_request(make_req(CMD_REMOVE, 32'h0, 4'd0));
    offer_request(make_req(CMD_NONE, 32'h0, 4'd0));
    // A zero limit refuses every insert but leaves the keys readable.
    drain_table();
    write_capacity(5'd0);
    offer_request(make_req(CMD_INSERT, 32'h0000_0001, 4'd0));
    offer_request(make_req(CMD_READ, 32'h0, 4'd0));
    // Limit lowered below the count: keys stay, inserts are refused until removes make room.
    drain_table();
    write_capacity(5'd2);
    offer_request(make_req(CMD_INSERT, 32'h0000_0002, 4'd0));
    offer_request(make_req(CMD_REMOVE, 32'h0, 4'd0));
    offer_request(make_req(CMD_REMOVE, 32'h0, 4'd0));
    offer_request(make_req(CMD_INSERT, 32'h0000_0003, 4'd0));
    offer_request(make_req(CMD_INSERT, 32'h0000_0004, 4'd0));

    phase_caps = '{5'd31, 5'd1, 5'd16, 5'd0, 5'd3, 5'($urandom_range(0, 31)), 5'd16,
                   5'($urandom_range(1, 16)), 5'd8};
    for (int ph = 0; ph < PhaseCount; ph++) begin
      drain_table();
      write_capacity(phase_caps[ph]);
      case (ph % 3)
        0:       insert_pct = 70;
        1:       insert_pct = 45;
        default: insert_pct = 25;
      endcase
      for (int n = 0; n < PhaseItems; n++) offer_request(random_request(insert_pct));
    end

    drain_table();
    if (fails == 0 && pending == 0) begin
      $display("tb_sorted_array_table_core: done, clean");
    end else begin
      $display("tb_sorted_array_table_core: done, errors");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
rtl/core/sat_pkg.sv
rtl/core/sat_ram.sv
rtl/core/sat_ctrl.sv
rtl/core/sat_datapath.sv
rtl/core/sorted_array_table_core.sv
tb/sat_table_checker.sv
tb/tb_sorted_array_table_core.sv
